>>> sv/positional_ordered_list_defines.svh
// Assertion macros shared by the checker file of the ordered list block.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define PLO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PLO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/plo_pkg.sv
// Package with the types, sizes and codes of the ordered list block.
`default_nettype none
package plo_pkg;

  // Storage sizes.
  localparam int CAPACITY  = 16;
  localparam int DATA_BITS = 32;

  // Derived widths.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = CNT_W + 8;

  // Fixed field widths of the channels.
  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int ELEM_W = 32;
  localparam int LEN_W  = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ      = 3'd6;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_APPENDED  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  // Cell chain commands.
  localparam logic [1:0] CM_HOLD = 2'd0;
  localparam logic [1:0] CM_INS  = 2'd1;
  localparam logic [1:0] CM_DEL  = 2'd2;
  localparam logic [1:0] CM_ROT  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [ELEM_W-1:0] element;
    logic                     element_valid;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic [1:0]           mode;
    logic [IDX_W-1:0]     idx;
    logic [CNT_W-1:0]     count;
    logic [DATA_BITS-1:0] word;
  } cell_cmd_t;

  // Sign-extend (or truncate) a stored word to the element field width.
  function automatic logic signed [ELEM_W-1:0] elem_of(input logic [DATA_BITS-1:0] d);
    logic signed [DATA_BITS-1:0] s;
    s = d;
    return ELEM_W'(s);
  endfunction

endpackage
`default_nettype wire

>>> sv/plo_cell.sv
// One slot of the list chain: holds a word and shifts with its neighbors.
`default_nettype none
module plo_cell (
  input  wire logic                           clk,
  input  wire plo_pkg::cell_cmd_t             cmd,
  input  wire logic [plo_pkg::IDX_W-1:0]      slot,
  input  wire logic [plo_pkg::DATA_BITS-1:0]  left_data,
  input  wire logic [plo_pkg::DATA_BITS-1:0]  right_data,
  output logic      [plo_pkg::DATA_BITS-1:0]  data
);
  import plo_pkg::*;

  logic [DATA_BITS-1:0] data_r;
  logic [DATA_BITS-1:0] data_nxt;
  logic [CNT_W-1:0]     slot_next;

  // Position one past this slot, compared against the list length.
  assign slot_next = CNT_W'(slot) + CNT_W'(1);

  // Insert opens a gap, delete closes one, rotate moves the head to the tail.
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.mode)
      CM_INS: begin
        if (slot > cmd.idx) begin
          data_nxt = left_data;
        end else if (slot == cmd.idx) begin
          data_nxt = cmd.word;
        end
      end
      CM_DEL: begin
        if (slot >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CM_ROT: begin
        if (slot_next == cmd.count) begin
          data_nxt = cmd.word;
        end else if (slot_next < cmd.count) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

>>> sv/positional_ordered_list.sv
// Top level of the ordered list: request decode, length, result register and cell chain.
//
// Usage: each input request on the in_ channel is one list operation (insert front,
// back or at a position, delete front, back or at a position, or read out).
// Results leave on the out_ channel through one output register; a request is
// accepted when in_valid is high and in_stall is low, likewise for results.
// Edits give one result in the cycle after acceptance, so back-to-back edits run
// at one request per cycle while the receiver keeps up. Read out gives one result
// per stored entry (one result for an empty list), one per cycle while the
// receiver keeps up: the chain rotates by one slot per element, bringing each
// word to the head cell, and after length rotations it stands as before. A read
// keeps in_stall high until its last result is loaded into the output register.
// in_stall is high during a read out and whenever the output register is full
// and stalled; a stalled result holds unchanged. Reset empties the list and
// drops any pending result; the stored words themselves are not cleared.
`default_nettype none
module positional_ordered_list (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire plo_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output plo_pkg::out_t      out_data
);
  import plo_pkg::*;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  cell_cmd_t            cmd;
  logic [DATA_BITS-1:0] cell_data [CAPACITY];

  logic                 out_free;
  logic                 accept;
  logic [DATA_BITS-1:0] word;
  logic                 pos_le1;
  logic                 pos_neg;
  logic [CMP_W-1:0]     pos_u;
  logic [CMP_W-1:0]     cnt_u;
  logic                 emit;
  out_t                 res;

  // Handshake.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !out_free;
  assign accept   = in_valid && !in_stall;

  // Operand preparation.
  assign word    = DATA_BITS'(in_data.value);
  assign pos_le1 = in_data.position <= 8'sd1;
  assign pos_neg = in_data.position[POS_W-1];
  assign pos_u   = CMP_W'(in_data.position[POS_W-2:0]);
  assign cnt_u   = CMP_W'(count_r);

  // Decode the request or the next read out step into a chain command and a result.
  always_comb begin
    cmd           = '{mode: CM_HOLD, idx: '0, count: count_r, word: word};
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    left_nxt      = left_r;
    emit          = 1'b0;
    res           = '0;
    res.status    = ST_OK;
    res.last      = 1'b1;
    if (busy_r) begin
      if (out_free) begin
        emit              = 1'b1;
        cmd.mode          = CM_ROT;
        cmd.word          = cell_data[0];
        res.element       = elem_of(cell_data[0]);
        res.element_valid = 1'b1;
        res.last          = (left_r == CNT_W'(1));
        left_nxt          = left_r - CNT_W'(1);
        busy_nxt          = (left_r != CNT_W'(1));
      end
    end else if (accept) begin
      emit = 1'b1;
      unique case (in_data.op) inside
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if (count_r == CNT_W'(CAPACITY)) begin
            res.status = ST_FULL;
          end else begin
            cmd.mode  = CM_INS;
            count_nxt = count_r + CNT_W'(1);
            if (in_data.op == OP_INS_FRONT || (in_data.op == OP_INS_AT && pos_le1)) begin
              cmd.idx = '0;
            end else if (in_data.op == OP_INS_BACK) begin
              cmd.idx = IDX_W'(count_r);
            end else if (pos_u > cnt_u + CMP_W'(1)) begin
              cmd.idx    = IDX_W'(count_r);
              res.status = ST_APPENDED;
            end else begin
              cmd.idx = IDX_W'(pos_u - CMP_W'(1));
            end
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (count_r == '0) begin
            res.status = ST_EMPTY;
          end else begin
            cmd.mode  = CM_DEL;
            cmd.idx   = (in_data.op == OP_DEL_FRONT) ? '0 : IDX_W'(count_r - CNT_W'(1));
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_DEL_AT: begin
          if (count_r == '0) begin
            res.status = ST_EMPTY;
          end else if (pos_neg || pos_u == '0 || pos_u > cnt_u) begin
            res.status = ST_NOT_FOUND;
          end else begin
            cmd.mode  = CM_DEL;
            cmd.idx   = IDX_W'(pos_u - CMP_W'(1));
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_READ: begin
          if (count_r != '0) begin
            cmd.mode          = CM_ROT;
            cmd.word          = cell_data[0];
            res.element       = elem_of(cell_data[0]);
            res.element_valid = 1'b1;
            res.last          = (count_r == CNT_W'(1));
            busy_nxt          = (count_r != CNT_W'(1));
            left_nxt          = count_r - CNT_W'(1);
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
    res.length = LEN_W'(count_nxt);
  end

  // Output register: loads a new result when free, otherwise holds.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Chain of cells; slot 0 is the head of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plo_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (IDX_W'(i)),
      .left_data  ((i == 0) ? cmd.word : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data       (cell_data[i])
    );
  end

endmodule
`default_nettype wire

>>> sv/plo_chk.sv
// Port-level checker of the ordered list, with its bind to the top level.
`default_nettype none
`include "positional_ordered_list_defines.svh"
module plo_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire plo_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire plo_pkg::out_t out_data
);
  import plo_pkg::*;

  // A stalled result stays put.
  `PLO_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_data), "result changed under stall")

  // The reported length never exceeds the capacity.
  `PLO_ASSERT_NOW(a_len_max, out_valid, out_data.length <= LEN_W'(CAPACITY),
                  "length beyond capacity")

  // Only read out gives more than one result, and each of those carries an entry.
  `PLO_ASSERT_NOW(a_multi_read, out_valid && !out_data.last,
                  out_data.element_valid && out_data.status == ST_OK,
                  "non-final result without entry")

  // A result without an entry carries a zero element.
  `PLO_ASSERT_NOW(a_elem_zero, out_valid && !out_data.element_valid,
                  out_data.element == '0, "element set without entry")

  // Any request other than read out gives one final result without an entry next cycle.
  `PLO_ASSERT_NEXT(a_edit_single, in_valid && !in_stall && in_data.op != OP_READ,
                   out_valid && out_data.last && !out_data.element_valid,
                   "edit result missing or carrying an entry")

endmodule

bind positional_ordered_list plo_chk u_plo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
